// File: rtl/core/assert_macros.svh
// Assertion macros shared by the request line parser RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge, disabled while reset is high.
`define HRLP_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define HRLP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/core/hrlp_pkg.sv
// Package for the HTTP request line parser: payload structs, state and code enums,
// character constants and character class functions. Depends on nothing.
package hrlp_pkg;

   localparam int VERSION_BITS_DEF = 16;
   localparam int VER_OUT_BITS     = 16;

   typedef enum logic [4:0] {
      ST_METHOD_START  = 5'd0,
      ST_METHOD        = 5'd1,
      ST_URI_START     = 5'd2,
      ST_URI           = 5'd3,
      ST_VER_H         = 5'd4,
      ST_VER_T1        = 5'd5,
      ST_VER_T2        = 5'd6,
      ST_VER_P         = 5'd7,
      ST_VER_SLASH     = 5'd8,
      ST_MAJOR_START   = 5'd9,
      ST_MAJOR         = 5'd10,
      ST_MINOR_START   = 5'd11,
      ST_MINOR         = 5'd12,
      ST_LF_AFTER_VER  = 5'd13,
      ST_LINE_START    = 5'd14,
      ST_LWS           = 5'd15,
      ST_NAME          = 5'd16,
      ST_SPACE_BEFORE  = 5'd17,
      ST_VALUE         = 5'd18,
      ST_LF_AFTER_LINE = 5'd19,
      ST_LF_FINAL      = 5'd20
   } state_type;

   typedef enum logic [1:0] {
      STAT_MORE   = 2'd0,
      STAT_DONE   = 2'd1,
      STAT_REJECT = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ROLE_NONE    = 3'd0,
      ROLE_METHOD  = 3'd1,
      ROLE_URI     = 3'd2,
      ROLE_NEWNAME = 3'd3,
      ROLE_NAME    = 3'd4,
      ROLE_VALUE   = 3'd5
   } role_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       restart;
   } req_type;

   typedef struct packed {
      status_type                status;
      role_type                  byte_role;
      logic [7:0]                echo_byte;
      logic [VER_OUT_BITS-1:0]   version_major;
      logic [VER_OUT_BITS-1:0]   version_minor;
   } rsp_type;

   // Decoded result of one byte against the current parser state.
   typedef struct packed {
      state_type  next_state;
      logic       header_seen;
      status_type status;
      role_type   role;
      logic       clr_ver;
      logic       major_step;
      logic       minor_step;
   } dec_type;

   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SP    = 8'h20;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_H     = 8'h48;
   localparam logic [7:0] CH_P     = 8'h50;
   localparam logic [7:0] CH_T     = 8'h54;
   localparam logic [7:0] CTL_MAX  = 8'd31;
   localparam logic [7:0] CH_DEL   = 8'd127;

   function automatic logic is_ctl(input logic [7:0] c);
      return (c <= CTL_MAX) || (c == CH_DEL);
   endfunction

   function automatic logic is_sep(input logic [7:0] c);
      logic r;
      unique case (c)
         8'h28, 8'h29, 8'h3C, 8'h3E, 8'h40,
         8'h2C, 8'h3B, 8'h3A, 8'h5C, 8'h22,
         8'h2F, 8'h5B, 8'h5D, 8'h3F, 8'h3D,
         8'h7B, 8'h7D, 8'h20, 8'h09: r = 1'b1;
         default:                    r = 1'b0;
      endcase
      return r;
   endfunction

   function automatic logic is_token(input logic [7:0] c);
      return !c[7] && !is_ctl(c) && !is_sep(c);
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= CH_ZERO) && (c <= CH_NINE);
   endfunction

endpackage

// File: rtl/core/http_request_line_parser_core.sv
// HTTP request parser top level: one request byte in, one result out per cycle.
// A byte taken into the byte register moves on to the result register, which drives rsp_valid.
// Throughput is one byte per cycle; the byte register and the result register keep flowing
// as long as rsp_stall is low, and the parser state updates as a byte moves to the result.
// Synchronous reset empties both registers and returns the parser to the method start.
// Depends on hrlp_pkg, hrlp_decode, hrlp_acc and assert_macros.svh.
`include "assert_macros.svh"

module http_request_line_parser_core #(
   parameter int VERSION_BITS = hrlp_pkg::VERSION_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  hrlp_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output hrlp_pkg::rsp_type rsp_data
);
   import hrlp_pkg::*;

   logic                    in_valid_ff, in_valid_in;
   req_type                 in_data_ff;
   logic                    out_valid_ff, out_valid_in;
   rsp_type                 out_data_ff, out_data_in;

   state_type               state_ff, state_in;
   logic                    header_seen_ff, header_seen_in;
   logic [VERSION_BITS-1:0] major_ff, major_in;
   logic [VERSION_BITS-1:0] minor_ff, minor_in;

   state_type               cur_state;
   logic                    cur_hs;
   logic [VERSION_BITS-1:0] cur_major, cur_minor;
   logic [VERSION_BITS-1:0] major_step_val, minor_step_val;
   logic [VERSION_BITS+VER_OUT_BITS-1:0] major_ext, minor_ext;
   dec_type                 dec;
   logic                    advance;
   logic                    req_take;

   // A result slot is free when empty or when its result is taken this cycle.
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   // Restart takes effect before the byte is parsed.
   assign cur_state = in_data_ff.restart ? ST_METHOD_START : state_ff;
   assign cur_hs    = in_data_ff.restart ? 1'b0 : header_seen_ff;
   assign cur_major = in_data_ff.restart ? '0 : major_ff;
   assign cur_minor = in_data_ff.restart ? '0 : minor_ff;

   hrlp_decode u_decode (
      .state       (cur_state),
      .header_seen (cur_hs),
      .data_byte   (in_data_ff.data_byte),
      .dec         (dec)
   );

   hrlp_acc #(.VERSION_BITS(VERSION_BITS)) u_major_acc (
      .acc      (cur_major),
      .digit    (in_data_ff.data_byte[3:0]),
      .acc_next (major_step_val)
   );

   hrlp_acc #(.VERSION_BITS(VERSION_BITS)) u_minor_acc (
      .acc      (cur_minor),
      .digit    (in_data_ff.data_byte[3:0]),
      .acc_next (minor_step_val)
   );

   always_comb begin
      major_in = cur_major;
      minor_in = cur_minor;
      if (dec.clr_ver) begin
         major_in = '0;
         minor_in = '0;
      end
      if (dec.major_step) major_in = major_step_val;
      if (dec.minor_step) minor_in = minor_step_val;
   end

   assign state_in       = advance ? dec.next_state : state_ff;
   assign header_seen_in = advance ? dec.header_seen : header_seen_ff;

   assign major_ext = {{VER_OUT_BITS{1'b0}}, major_in};
   assign minor_ext = {{VER_OUT_BITS{1'b0}}, minor_in};

   always_comb begin
      out_data_in.status        = dec.status;
      out_data_in.byte_role     = dec.role;
      out_data_in.echo_byte     = in_data_ff.data_byte;
      out_data_in.version_major = major_ext[VER_OUT_BITS-1:0];
      out_data_in.version_minor = minor_ext[VER_OUT_BITS-1:0];
   end

   assign in_valid_in  = req_take ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign out_valid_in = advance ? 1'b1 : (rsp_stall ? out_valid_ff : 1'b0);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         out_valid_ff   <= 1'b0;
         state_ff       <= ST_METHOD_START;
         header_seen_ff <= 1'b0;
         major_ff       <= '0;
         minor_ff       <= '0;
      end else begin
         in_valid_ff    <= in_valid_in;
         out_valid_ff   <= out_valid_in;
         state_ff       <= state_in;
         header_seen_ff <= header_seen_in;
         if (advance) begin
            major_ff <= major_in;
            minor_ff <= minor_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) in_data_ff <= req_data;
      if (advance) out_data_ff <= out_data_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   `HRLP_ASSERT(a_reject_holds_state, clock, reset, advance && dec.status == STAT_REJECT |=> state_ff == $past(cur_state), "rejected byte changed the parser state")
   `HRLP_ASSERT(a_done_in_final, clock, reset, advance && dec.status == STAT_DONE |=> state_ff == ST_LF_FINAL, "complete status outside the final newline wait")
   `HRLP_ASSERT(a_role_only_more, clock, reset, rsp_valid && rsp_data.byte_role != ROLE_NONE |-> rsp_data.status == STAT_MORE, "field byte reported with a final status")
   `HRLP_ASSERT(a_held_byte_kept, clock, reset, in_valid_ff && !advance |=> in_valid_ff && $stable(in_data_ff), "held request lost from the byte register")
endmodule

// File: rtl/core/hrlp_acc.sv
// Saturating decimal digit accumulator: acc * 10 + digit, clamped to all ones.
// Depends on nothing.
module hrlp_acc #(
   parameter int VERSION_BITS = 16
) (
   input  logic [VERSION_BITS-1:0] acc,
   input  logic [3:0]              digit,
   output logic [VERSION_BITS-1:0] acc_next
);
   logic [VERSION_BITS+3:0] sum;

   // Times ten is a shift-by-three plus a shift-by-one.
   assign sum = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {{VERSION_BITS{1'b0}}, digit};

   assign acc_next = (sum[VERSION_BITS+3:VERSION_BITS] != 4'd0) ?
                     {VERSION_BITS{1'b1}} : sum[VERSION_BITS-1:0];
endmodule

// File: rtl/core/hrlp_decode.sv
// Per-byte decode of the request parser state machine: next state and byte outputs.
// Depends on hrlp_pkg.
module hrlp_decode (
   input  hrlp_pkg::state_type state,
   input  logic                header_seen,
   input  logic [7:0]          data_byte,
   output hrlp_pkg::dec_type   dec
);
   import hrlp_pkg::*;

   state_type  next_state;
   logic       hs_next;
   status_type status;
   role_type   role;
   logic       clr_ver;
   logic       major_step;
   logic       minor_step;
   logic       c_ws;

   assign c_ws = (data_byte == CH_SP) || (data_byte == CH_TAB);

   // Next state.
   always_comb begin
      next_state = state;
      hs_next    = header_seen;
      unique case (state)
         ST_METHOD_START: if (is_token(data_byte)) next_state = ST_METHOD;
         ST_METHOD:       if (data_byte == CH_SP) next_state = ST_URI_START;
         ST_URI_START:    if (!is_ctl(data_byte)) next_state = ST_URI;
         ST_URI:          if (data_byte == CH_SP) next_state = ST_VER_H;
         ST_VER_H:        if (data_byte == CH_H) next_state = ST_VER_T1;
         ST_VER_T1:       if (data_byte == CH_T) next_state = ST_VER_T2;
         ST_VER_T2:       if (data_byte == CH_T) next_state = ST_VER_P;
         ST_VER_P:        if (data_byte == CH_P) next_state = ST_VER_SLASH;
         ST_VER_SLASH:    if (data_byte == CH_SLASH) next_state = ST_MAJOR_START;
         ST_MAJOR_START:  if (is_digit(data_byte)) next_state = ST_MAJOR;
         ST_MAJOR:        if (data_byte == CH_DOT) next_state = ST_MINOR_START;
         ST_MINOR_START:  if (is_digit(data_byte)) next_state = ST_MINOR;
         ST_MINOR:        if (data_byte == CH_CR) next_state = ST_LF_AFTER_VER;
         ST_LF_AFTER_VER: if (data_byte == CH_LF) next_state = ST_LINE_START;
         ST_LINE_START: begin
            priority if (data_byte == CH_CR) next_state = ST_LF_FINAL;
            else if (header_seen && c_ws) next_state = ST_LWS;
            else if (is_token(data_byte)) begin
               next_state = ST_NAME;
               hs_next    = 1'b1;
            end else next_state = state;
         end
         ST_LWS: begin
            priority if (data_byte == CH_CR) next_state = ST_LF_AFTER_LINE;
            else if (!c_ws && !is_ctl(data_byte)) next_state = ST_VALUE;
            else next_state = state;
         end
         ST_NAME:          if (data_byte == CH_COLON) next_state = ST_SPACE_BEFORE;
         ST_SPACE_BEFORE:  if (data_byte == CH_SP) next_state = ST_VALUE;
         ST_VALUE:         if (data_byte == CH_CR) next_state = ST_LF_AFTER_LINE;
         ST_LF_AFTER_LINE: if (data_byte == CH_LF) next_state = ST_LINE_START;
         ST_LF_FINAL:      next_state = ST_LF_FINAL;
         default:          next_state = state;
      endcase
   end

   // Status, role and version accumulator controls.
   always_comb begin
      status     = STAT_MORE;
      role       = ROLE_NONE;
      clr_ver    = 1'b0;
      major_step = 1'b0;
      minor_step = 1'b0;
      unique case (state)
         ST_METHOD_START: begin
            if (is_token(data_byte)) role = ROLE_METHOD;
            else status = STAT_REJECT;
         end
         ST_METHOD: begin
            priority if (data_byte == CH_SP) role = ROLE_NONE;
            else if (is_token(data_byte)) role = ROLE_METHOD;
            else status = STAT_REJECT;
         end
         ST_URI_START: begin
            if (is_ctl(data_byte)) status = STAT_REJECT;
            else role = ROLE_URI;
         end
         ST_URI: begin
            priority if (data_byte == CH_SP) role = ROLE_NONE;
            else if (is_ctl(data_byte)) status = STAT_REJECT;
            else role = ROLE_URI;
         end
         ST_VER_H:  if (data_byte != CH_H) status = STAT_REJECT;
         ST_VER_T1: if (data_byte != CH_T) status = STAT_REJECT;
         ST_VER_T2: if (data_byte != CH_T) status = STAT_REJECT;
         ST_VER_P:  if (data_byte != CH_P) status = STAT_REJECT;
         ST_VER_SLASH: begin
            if (data_byte == CH_SLASH) clr_ver = 1'b1;
            else status = STAT_REJECT;
         end
         ST_MAJOR_START: begin
            if (is_digit(data_byte)) major_step = 1'b1;
            else status = STAT_REJECT;
         end
         ST_MAJOR: begin
            priority if (data_byte == CH_DOT) role = ROLE_NONE;
            else if (is_digit(data_byte)) major_step = 1'b1;
            else status = STAT_REJECT;
         end
         ST_MINOR_START: begin
            if (is_digit(data_byte)) minor_step = 1'b1;
            else status = STAT_REJECT;
         end
         ST_MINOR: begin
            priority if (data_byte == CH_CR) role = ROLE_NONE;
            else if (is_digit(data_byte)) minor_step = 1'b1;
            else status = STAT_REJECT;
         end
         ST_LF_AFTER_VER: if (data_byte != CH_LF) status = STAT_REJECT;
         ST_LINE_START: begin
            priority if (data_byte == CH_CR) role = ROLE_NONE;
            else if (header_seen && c_ws) role = ROLE_NONE;
            else if (is_token(data_byte)) role = ROLE_NEWNAME;
            else status = STAT_REJECT;
         end
         ST_LWS: begin
            priority if (data_byte == CH_CR || c_ws) role = ROLE_NONE;
            else if (is_ctl(data_byte)) status = STAT_REJECT;
            else role = ROLE_VALUE;
         end
         ST_NAME: begin
            priority if (data_byte == CH_COLON) role = ROLE_NONE;
            else if (is_token(data_byte)) role = ROLE_NAME;
            else status = STAT_REJECT;
         end
         ST_SPACE_BEFORE: if (data_byte != CH_SP) status = STAT_REJECT;
         ST_VALUE: begin
            priority if (data_byte == CH_CR) role = ROLE_NONE;
            else if (is_ctl(data_byte)) status = STAT_REJECT;
            else role = ROLE_VALUE;
         end
         ST_LF_AFTER_LINE: if (data_byte != CH_LF) status = STAT_REJECT;
         ST_LF_FINAL: status = (data_byte == CH_LF) ? STAT_DONE : STAT_REJECT;
         default:     status = STAT_REJECT;
      endcase
   end

   assign dec.next_state  = next_state;
   assign dec.header_seen = hs_next;
   assign dec.status      = status;
   assign dec.role        = role;
   assign dec.clr_ver     = clr_ver;
   assign dec.major_step  = major_step;
   assign dec.minor_step  = minor_step;
endmodule

// File: bench/http_request_line_parser_core_tb.sv
// Testbench for http_request_line_parser_core: drives request bytes, predicts each result
// with a parser model of its own and checks every result field. Depends on hrlp_pkg.
`timescale 1ns / 1ps

module http_request_line_parser_core_tb;
   import hrlp_pkg::*;

   localparam int          HALF_PERIOD      = 5;
   localparam int          WATCHDOG_CYCLES  = 2000;
   localparam int          HOLD_OFF_CYCLES  = 60;
   localparam int          MAX_REPORTS      = 10;
   localparam int unsigned VERSION_MAX      = (1 << VERSION_BITS_DEF) - 1;
   localparam string       SEPARATOR_CHARS  = "()<>@,;:\\\"/[]?={} \t";

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   // Parser state as predicted from the accepted requests.
   state_type   line_state = ST_METHOD_START;
   int unsigned major_ver  = 0;
   int unsigned minor_ver  = 0;
   bit          any_header = 1'b0;

   rsp_type expected_rsp[$];
   int      mismatch_count  = 0;
   int      items_sent      = 0;
   int      sender_idle_pct = 0;
   int      stall_pct       = 0;
   int      hold_off_asked  = 0;
   int      hold_off_taken  = 0;
   int      hold_off_left   = 0;
   int      idle_cycles     = 0;

   http_request_line_parser_core uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #HALF_PERIOD clock = ~clock;

   function automatic bit control_char(input logic [7:0] c);
      return (c <= CTL_MAX) || (c == CH_DEL);
   endfunction

   function automatic bit separator_char(input logic [7:0] c);
      bit hit;
      hit = 1'b0;
      for (int i = 0; i < SEPARATOR_CHARS.len(); i++)
         if (c == SEPARATOR_CHARS[i]) hit = 1'b1;
      return hit;
   endfunction

   function automatic bit token_char(input logic [7:0] c);
      return !c[7] && !control_char(c) && !separator_char(c);
   endfunction

   function automatic bit digit_char(input logic [7:0] c);
      return (c >= CH_ZERO) && (c <= CH_NINE);
   endfunction

   function automatic int unsigned add_version_digit(input int unsigned acc,
                                                     input logic [7:0] c);
      int unsigned v;
      v = acc * 10 + (c - CH_ZERO);
      return (v > VERSION_MAX) ? VERSION_MAX : v;
   endfunction

   // Advances the predicted parser by one byte and returns the result it should give.
   function automatic rsp_type parse_byte(input req_type r);
      rsp_type    res;
      logic [7:0] c;
      state_type  nxt;
      status_type st;
      role_type   role;
      c = r.data_byte;
      if (r.restart) begin
         line_state = ST_METHOD_START;
         major_ver  = 0;
         minor_ver  = 0;
         any_header = 1'b0;
      end
      nxt  = line_state;
      st   = STAT_MORE;
      role = ROLE_NONE;
      case (line_state)
         ST_METHOD_START: begin
            if (token_char(c)) begin
               nxt  = ST_METHOD;
               role = ROLE_METHOD;
            end else st = STAT_REJECT;
         end
         ST_METHOD: begin
            if (c == CH_SP) nxt = ST_URI_START;
            else if (token_char(c)) role = ROLE_METHOD;
            else st = STAT_REJECT;
         end
         ST_URI_START: begin
            if (control_char(c)) st = STAT_REJECT;
            else begin
               nxt  = ST_URI;
               role = ROLE_URI;
            end
         end
         ST_URI: begin
            if (c == CH_SP) nxt = ST_VER_H;
            else if (control_char(c)) st = STAT_REJECT;
            else role = ROLE_URI;
         end
         ST_VER_H:  if (c == CH_H) nxt = ST_VER_T1; else st = STAT_REJECT;
         ST_VER_T1: if (c == CH_T) nxt = ST_VER_T2; else st = STAT_REJECT;
         ST_VER_T2: if (c == CH_T) nxt = ST_VER_P; else st = STAT_REJECT;
         ST_VER_P:  if (c == CH_P) nxt = ST_VER_SLASH; else st = STAT_REJECT;
         ST_VER_SLASH: begin
            if (c == CH_SLASH) begin
               major_ver = 0;
               minor_ver = 0;
               nxt       = ST_MAJOR_START;
            end else st = STAT_REJECT;
         end
         ST_MAJOR_START: begin
            if (digit_char(c)) begin
               major_ver = add_version_digit(major_ver, c);
               nxt       = ST_MAJOR;
            end else st = STAT_REJECT;
         end
         ST_MAJOR: begin
            if (c == CH_DOT) nxt = ST_MINOR_START;
            else if (digit_char(c)) major_ver = add_version_digit(major_ver, c);
            else st = STAT_REJECT;
         end
         ST_MINOR_START: begin
            if (digit_char(c)) begin
               minor_ver = add_version_digit(minor_ver, c);
               nxt       = ST_MINOR;
            end else st = STAT_REJECT;
         end
         ST_MINOR: begin
            if (c == CH_CR) nxt = ST_LF_AFTER_VER;
            else if (digit_char(c)) minor_ver = add_version_digit(minor_ver, c);
            else st = STAT_REJECT;
         end
         ST_LF_AFTER_VER: if (c == CH_LF) nxt = ST_LINE_START; else st = STAT_REJECT;
         ST_LINE_START: begin
            if (c == CH_CR) nxt = ST_LF_FINAL;
            else if (any_header && (c == CH_SP || c == CH_TAB)) nxt = ST_LWS;
            else if (token_char(c)) begin
               any_header = 1'b1;
               role       = ROLE_NEWNAME;
               nxt        = ST_NAME;
            end else st = STAT_REJECT;
         end
         ST_LWS: begin
            if (c == CH_CR) nxt = ST_LF_AFTER_LINE;
            else if (c == CH_SP || c == CH_TAB) nxt = ST_LWS;
            else if (control_char(c)) st = STAT_REJECT;
            else begin
               nxt  = ST_VALUE;
               role = ROLE_VALUE;
            end
         end
         ST_NAME: begin
            if (c == CH_COLON) nxt = ST_SPACE_BEFORE;
            else if (token_char(c)) role = ROLE_NAME;
            else st = STAT_REJECT;
         end
         ST_SPACE_BEFORE: if (c == CH_SP) nxt = ST_VALUE; else st = STAT_REJECT;
         ST_VALUE: begin
            if (c == CH_CR) nxt = ST_LF_AFTER_LINE;
            else if (control_char(c)) st = STAT_REJECT;
            else role = ROLE_VALUE;
         end
         ST_LF_AFTER_LINE: if (c == CH_LF) nxt = ST_LINE_START; else st = STAT_REJECT;
         ST_LF_FINAL: st = (c == CH_LF) ? STAT_DONE : STAT_REJECT;
         default: st = STAT_REJECT;
      endcase
      line_state        = nxt;
      res.status        = st;
      res.byte_role     = role;
      res.echo_byte     = c;
      res.version_major = major_ver[VER_OUT_BITS-1:0];
      res.version_minor = minor_ver[VER_OUT_BITS-1:0];
      return res;
   endfunction

   function automatic logic [7:0] pick_token_char();
      logic [7:0] c;
      do c = 8'($urandom_range(33, 126)); while (!token_char(c));
      return c;
   endfunction

   // URI bytes: anything but controls and the space that ends the URI.
   function automatic logic [7:0] pick_uri_char();
      logic [7:0] c;
      do c = 8'($urandom_range(33, 255)); while (c == CH_DEL);
      return c;
   endfunction

   function automatic logic [7:0] pick_value_char();
      logic [7:0] c;
      do c = 8'($urandom_range(32, 255)); while (c == CH_DEL);
      return c;
   endfunction

   function automatic logic [7:0] pick_digit();
      return CH_ZERO + 8'($urandom_range(9));
   endfunction

   task automatic flag_error(input string msg);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS) $display("ERROR: %s", msg);
   endtask

   // Adds one byte at the end of a request text.
   task automatic append_byte(ref logic [7:0] q[$], input logic [7:0] b);
      q.insert(q.size(), b);
   endtask

   // Offers one request and returns once it has been accepted.
   task automatic send_item(input logic [7:0] b, input logic restart_bit);
      if (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{data_byte: b, restart: restart_bit};
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
   endtask

   // The sender pauses until every predicted result has been checked.
   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (expected_rsp.size() != 0) @(posedge clock);
   endtask

   // Builds a well-formed request with random content; a broken one gets one byte
   // replaced by a random value and may be cut short after it.
   task automatic send_http_request(input bit broken);
      logic [7:0] text[$];
      int         spot;
      repeat ($urandom_range(1, 6)) append_byte(text, pick_token_char());
      append_byte(text, CH_SP);
      repeat ($urandom_range(1, 8)) append_byte(text, pick_uri_char());
      append_byte(text, CH_SP);
      append_byte(text, CH_H);
      append_byte(text, CH_T);
      append_byte(text, CH_T);
      append_byte(text, CH_P);
      append_byte(text, CH_SLASH);
      repeat (($urandom_range(99) < 10) ? 6 : $urandom_range(1, 2))
         append_byte(text, pick_digit());
      append_byte(text, CH_DOT);
      repeat (($urandom_range(99) < 10) ? 6 : $urandom_range(1, 2))
         append_byte(text, pick_digit());
      append_byte(text, CH_CR);
      append_byte(text, CH_LF);
      repeat ($urandom_range(0, 3)) begin
         repeat ($urandom_range(1, 5)) append_byte(text, pick_token_char());
         append_byte(text, CH_COLON);
         append_byte(text, CH_SP);
         repeat ($urandom_range(0, 6)) append_byte(text, pick_value_char());
         append_byte(text, CH_CR);
         append_byte(text, CH_LF);
         if ($urandom_range(3) == 0) begin
            repeat ($urandom_range(1, 2)) append_byte(text, $urandom_range(1) ? CH_SP : CH_TAB);
            repeat ($urandom_range(0, 4)) append_byte(text, pick_value_char());
            append_byte(text, CH_CR);
            append_byte(text, CH_LF);
         end
      end
      append_byte(text, CH_CR);
      append_byte(text, CH_LF);
      if ($urandom_range(4) == 0) append_byte(text, CH_LF);
      if (broken) begin
         spot       = $urandom_range(text.size() - 1);
         text[spot] = 8'($urandom_range(255));
         if ($urandom_range(1))
            while (text.size() > spot + 1) void'(text.pop_back());
      end
      foreach (text[i]) send_item(text[i], i == 0);
   endtask

   task automatic run_random_traffic(input int item_budget);
      int stop_at;
      int pick;
      stop_at = items_sent + item_budget;
      while (items_sent < stop_at) begin
         pick = $urandom_range(99);
         if (pick < 10) begin
            repeat ($urandom_range(1, 6))
               send_item(8'($urandom_range(255)), $urandom_range(7) == 0);
         end else send_http_request(pick < 25);
      end
   endtask

   // Walks one request through every field, with rejections, a saturating major
   // version, a continuation before any header, and a repeated final newline.
   task automatic test_directed_request();
      sender_idle_pct = 0;
      stall_pct       = 0;
      send_item(8'h00, 1'b1);
      send_item(8'hFF, 1'b0);
      send_text("G");
      send_item(CH_SP, 1'b0);
      send_item(8'hFF, 1'b0);
      send_item(CH_SP, 1'b0);
      send_text("HTTP/99999.0");
      send_item(CH_CR, 1'b0);
      send_item(CH_LF, 1'b0);
      send_item(CH_TAB, 1'b0);
      send_text("Hs: x");
      send_item(CH_CR, 1'b0);
      send_item(CH_LF, 1'b0);
      send_item(CH_TAB, 1'b0);
      send_item(CH_CR, 1'b0);
      send_item(CH_LF, 1'b0);
      send_item(CH_CR, 1'b0);
      send_item(CH_LF, 1'b0);
      send_item(CH_LF, 1'b0);
      wait_for_results();
   endtask

   task automatic test_random_requests(input int idle_pct, input int hold_pct);
      sender_idle_pct = idle_pct;
      stall_pct       = hold_pct;
      run_random_traffic(60);
      wait_for_results();
   endtask

   // The receiver holds off for a long stretch while requests keep coming.
   task automatic test_output_hold_off();
      sender_idle_pct = 0;
      stall_pct       = 0;
      hold_off_asked++;
      run_random_traffic(50);
      wait_for_results();
   endtask

   always @(posedge clock) begin
      if (hold_off_taken != hold_off_asked) begin
         hold_off_taken = hold_off_asked;
         hold_off_left  = HOLD_OFF_CYCLES;
      end
      if (hold_off_left > 0) begin
         hold_off_left--;
         rsp_stall <= 1'b1;
      end else rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall)
         expected_rsp.insert(expected_rsp.size(), parse_byte(req_data));
   end

   always @(posedge clock) begin : check_results
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsp.size() == 0) begin
            flag_error($sformatf("result with nothing expected, echo_byte %0d",
                                 rsp_data.echo_byte));
         end else begin
            want = expected_rsp.pop_front();
            if (rsp_data.status !== want.status)
               flag_error($sformatf("status: expected %0d, got %0d",
                                    want.status, rsp_data.status));
            if (rsp_data.byte_role !== want.byte_role)
               flag_error($sformatf("byte_role: expected %0d, got %0d",
                                    want.byte_role, rsp_data.byte_role));
            if (rsp_data.echo_byte !== want.echo_byte)
               flag_error($sformatf("echo_byte: expected %0d, got %0d",
                                    want.echo_byte, rsp_data.echo_byte));
            if (rsp_data.version_major !== want.version_major)
               flag_error($sformatf("version_major: expected %0d, got %0d",
                                    want.version_major, rsp_data.version_major));
            if (rsp_data.version_minor !== want.version_minor)
               flag_error($sformatf("version_minor: expected %0d, got %0d",
                                    want.version_minor, rsp_data.version_minor));
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_CYCLES) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_directed_request();
      test_random_requests(0, 0);
      test_random_requests(52, 0);
      test_random_requests(0, 52);
      test_random_requests(25, 25);
      test_output_hold_off();
      repeat (4) @(posedge clock);
      if (mismatch_count == 0 && expected_rsp.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
